FILE: hdl/spdc_pkg.sv
package spdc_pkg;

	localparam int unsigned DW = 64;
	localparam int unsigned AW = 6;
	localparam int unsigned PCW = 7;

	typedef enum logic [3:0] {
		OP_MUL,
		OP_MULS,
		OP_MULW,
		OP_ADD,
		OP_SUB,
		OP_SAT,
		OP_DIV,
		OP_SQRT,
		OP_JLEU,
		OP_END
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [AW-1:0]   dst;
		logic [AW-1:0]   sa;
		logic [AW-1:0]   sb;
		logic [PCW-1:0]  tgt;
	} ucode_t;

	typedef struct packed {
		logic   rd;
		logic   ex;
		ucode_t uw;
	} ctl_t;

	typedef struct packed {
		logic unit_done;
		logic cond;
	} sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC,
		S_WAIT,
		S_DONE
	} seq_state_t;

	localparam logic [3:0] CFG_MASS  = 4'd0;
	localparam logic [3:0] CFG_INVM  = 4'd1;
	localparam logic [3:0] CFG_INVI  = 4'd2;
	localparam logic [3:0] CFG_FREQ  = 4'd3;
	localparam logic [3:0] CFG_RATIO = 4'd4;
	localparam logic [3:0] CFG_MAXI  = 4'd5;
	localparam logic [3:0] CFG_LX    = 4'd6;
	localparam logic [3:0] CFG_LY    = 4'd7;

	localparam logic signed [DW-1:0] K_ONE    = 64'sd65536;
	localparam logic signed [DW-1:0] K_TWOPI  = 64'sd411775;
	localparam logic signed [DW-1:0] K_DAMP   = 64'sd64881;
	localparam logic signed [DW-1:0] S32_MAX  = 64'sd2147483647;
	localparam logic signed [DW-1:0] S32_MIN  = -64'sd2147483648;

	localparam logic [AW-1:0] R_RX  = 6'd0;
	localparam logic [AW-1:0] R_RY  = 6'd1;
	localparam logic [AW-1:0] R_M11 = 6'd2;
	localparam logic [AW-1:0] R_M12 = 6'd3;
	localparam logic [AW-1:0] R_M22 = 6'd4;
	localparam logic [AW-1:0] R_BX  = 6'd5;
	localparam logic [AW-1:0] R_BY  = 6'd6;
	localparam logic [AW-1:0] R_IX  = 6'd7;
	localparam logic [AW-1:0] R_IY  = 6'd8;
	localparam logic [AW-1:0] T0  = 6'd9;
	localparam logic [AW-1:0] T1  = 6'd10;
	localparam logic [AW-1:0] T2  = 6'd11;
	localparam logic [AW-1:0] T3  = 6'd12;
	localparam logic [AW-1:0] T4  = 6'd13;
	localparam logic [AW-1:0] T5  = 6'd14;
	localparam logic [AW-1:0] T6  = 6'd15;
	localparam logic [AW-1:0] T7  = 6'd16;
	localparam logic [AW-1:0] T8  = 6'd17;
	localparam logic [AW-1:0] T9  = 6'd18;
	localparam logic [AW-1:0] T10 = 6'd19;
	localparam logic [AW-1:0] T11 = 6'd20;
	localparam logic [AW-1:0] T12 = 6'd21;
	localparam logic [AW-1:0] T13 = 6'd22;

	localparam logic [AW-1:0] A_VX    = 6'd32;
	localparam logic [AW-1:0] A_VY    = 6'd33;
	localparam logic [AW-1:0] A_W     = 6'd34;
	localparam logic [AW-1:0] A_DT    = 6'd35;
	localparam logic [AW-1:0] A_COS   = 6'd36;
	localparam logic [AW-1:0] A_SIN   = 6'd37;
	localparam logic [AW-1:0] A_PX    = 6'd38;
	localparam logic [AW-1:0] A_PY    = 6'd39;
	localparam logic [AW-1:0] A_TX    = 6'd40;
	localparam logic [AW-1:0] A_TY    = 6'd41;
	localparam logic [AW-1:0] A_MASS  = 6'd42;
	localparam logic [AW-1:0] A_INVM  = 6'd43;
	localparam logic [AW-1:0] A_INVI  = 6'd44;
	localparam logic [AW-1:0] A_FREQ  = 6'd45;
	localparam logic [AW-1:0] A_RATIO = 6'd46;
	localparam logic [AW-1:0] A_MAXI  = 6'd47;
	localparam logic [AW-1:0] A_LX    = 6'd48;
	localparam logic [AW-1:0] A_LY    = 6'd49;
	localparam logic [AW-1:0] A_ZERO  = 6'd50;
	localparam logic [AW-1:0] A_ONE   = 6'd51;
	localparam logic [AW-1:0] A_TWOPI = 6'd52;
	localparam logic [AW-1:0] A_DAMP  = 6'd53;

	localparam logic [AW-1:0] D_OUTX = 6'd32;
	localparam logic [AW-1:0] D_OUTY = 6'd33;
	localparam logic [AW-1:0] D_OUTW = 6'd34;

	localparam logic [PCW-1:0] PC_BUILD   = 7'd0;
	localparam logic [PCW-1:0] PC_CORRECT = 7'd73;
	localparam logic [PCW-1:0] PC_UPDATE  = 7'd105;

	function automatic logic signed [DW-1:0] sat32(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] r;
		r = v;
		if (v > S32_MAX) r = S32_MAX;
		if (v < S32_MIN) r = S32_MIN;
		return r;
	endfunction

	function automatic ucode_t uc(input op_t op, input logic [AW-1:0] d,
			input logic [AW-1:0] a, input logic [AW-1:0] b);
		ucode_t w;
		w.op  = op;
		w.dst = d;
		w.sa  = a;
		w.sb  = b;
		w.tgt = PC_UPDATE;
		return w;
	endfunction

	function automatic ucode_t rom_word(input logic [PCW-1:0] pc);
		ucode_t w;
		case (pc)
			7'd0: w = uc(OP_MUL, T0, A_COS, A_LX);
			7'd1: w = uc(OP_MUL, T1, A_SIN, A_LY);
			7'd2: w = uc(OP_SUB, T0, T0, T1);
			7'd3: w = uc(OP_SAT, R_RX, T0, A_ZERO);
			7'd4: w = uc(OP_MUL, T0, A_SIN, A_LX);
			7'd5: w = uc(OP_MUL, T1, A_COS, A_LY);
			7'd6: w = uc(OP_ADD, T0, T0, T1);
			7'd7: w = uc(OP_SAT, R_RY, T0, A_ZERO);
			7'd8: w = uc(OP_MULS, T2, A_TWOPI, A_FREQ);
			7'd9: w = uc(OP_MULS, T3, A_MASS, T2);
			7'd10: w = uc(OP_MULS, T3, T3, T2);
			7'd11: w = uc(OP_ADD, T4, A_RATIO, A_RATIO);
			7'd12: w = uc(OP_SAT, T4, T4, A_ZERO);
			7'd13: w = uc(OP_MULS, T4, T4, A_MASS);
			7'd14: w = uc(OP_MULS, T4, T4, T2);
			7'd15: w = uc(OP_MULS, T5, T3, A_DT);
			7'd16: w = uc(OP_ADD, T5, T4, T5);
			7'd17: w = uc(OP_SAT, T5, T5, A_ZERO);
			7'd18: w = uc(OP_MULS, T5, T5, A_DT);
			7'd19: w = uc(OP_MULW, T6, A_ONE, A_ONE);
			7'd20: w = uc(OP_DIV, T6, T6, T5);
			7'd21: w = uc(OP_MULS, T7, A_DT, T3);
			7'd22: w = uc(OP_MULS, T7, T7, T6);
			7'd23: w = uc(OP_MULS, T8, A_INVI, R_RY);
			7'd24: w = uc(OP_MUL, T8, T8, R_RY);
			7'd25: w = uc(OP_ADD, T8, T8, A_INVM);
			7'd26: w = uc(OP_ADD, T8, T8, T6);
			7'd27: w = uc(OP_SAT, T8, T8, A_ZERO);
			7'd28: w = uc(OP_MULS, T9, A_INVI, R_RX);
			7'd29: w = uc(OP_MUL, T10, T9, R_RX);
			7'd30: w = uc(OP_ADD, T10, T10, A_INVM);
			7'd31: w = uc(OP_ADD, T10, T10, T6);
			7'd32: w = uc(OP_SAT, T10, T10, A_ZERO);
			7'd33: w = uc(OP_MUL, T9, T9, R_RY);
			7'd34: w = uc(OP_SUB, T9, A_ZERO, T9);
			7'd35: w = uc(OP_SAT, T9, T9, A_ZERO);
			7'd36: w = uc(OP_MUL, T11, T8, T10);
			7'd37: w = uc(OP_MUL, T12, T9, T9);
			7'd38: w = uc(OP_SUB, T11, T11, T12);
			7'd39: w = uc(OP_SAT, T11, T11, A_ZERO);
			7'd40: w = uc(OP_MULW, T12, T10, A_ONE);
			7'd41: w = uc(OP_DIV, R_M11, T12, T11);
			7'd42: w = uc(OP_SUB, T12, A_ZERO, T9);
			7'd43: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd44: w = uc(OP_MULW, T12, T12, A_ONE);
			7'd45: w = uc(OP_DIV, R_M12, T12, T11);
			7'd46: w = uc(OP_MULW, T12, T8, A_ONE);
			7'd47: w = uc(OP_DIV, R_M22, T12, T11);
			7'd48: w = uc(OP_ADD, T12, A_PX, R_RX);
			7'd49: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd50: w = uc(OP_SUB, T12, T12, A_TX);
			7'd51: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd52: w = uc(OP_MULS, R_BX, T7, T12);
			7'd53: w = uc(OP_ADD, T12, A_PY, R_RY);
			7'd54: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd55: w = uc(OP_SUB, T12, T12, A_TY);
			7'd56: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd57: w = uc(OP_MULS, R_BY, T7, T12);
			7'd58: w = uc(OP_MUL, T12, R_IX, A_INVM);
			7'd59: w = uc(OP_ADD, T12, A_VX, T12);
			7'd60: w = uc(OP_SAT, D_OUTX, T12, A_ZERO);
			7'd61: w = uc(OP_MUL, T12, R_IY, A_INVM);
			7'd62: w = uc(OP_ADD, T12, A_VY, T12);
			7'd63: w = uc(OP_SAT, D_OUTY, T12, A_ZERO);
			7'd64: w = uc(OP_MUL, T12, R_RX, R_IY);
			7'd65: w = uc(OP_MUL, T13, R_RY, R_IX);
			7'd66: w = uc(OP_SUB, T12, T12, T13);
			7'd67: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd68: w = uc(OP_MUL, T12, A_INVI, T12);
			7'd69: w = uc(OP_ADD, T12, A_W, T12);
			7'd70: w = uc(OP_SAT, T12, T12, A_ZERO);
			7'd71: w = uc(OP_MULS, D_OUTW, T12, A_DAMP);
			7'd72: w = uc(OP_END, T0, A_ZERO, A_ZERO);
			7'd73: w = uc(OP_MUL, T0, A_W, R_RY);
			7'd74: w = uc(OP_SUB, T0, A_VX, T0);
			7'd75: w = uc(OP_ADD, T0, T0, R_BX);
			7'd76: w = uc(OP_SAT, T0, T0, A_ZERO);
			7'd77: w = uc(OP_MUL, T1, A_W, R_RX);
			7'd78: w = uc(OP_ADD, T1, A_VY, T1);
			7'd79: w = uc(OP_ADD, T1, T1, R_BY);
			7'd80: w = uc(OP_SAT, T1, T1, A_ZERO);
			7'd81: w = uc(OP_MUL, T2, R_M11, T0);
			7'd82: w = uc(OP_MUL, T3, R_M12, T1);
			7'd83: w = uc(OP_ADD, T2, T2, T3);
			7'd84: w = uc(OP_SUB, T2, A_ZERO, T2);
			7'd85: w = uc(OP_SAT, T2, T2, A_ZERO);
			7'd86: w = uc(OP_MUL, T3, R_M12, T0);
			7'd87: w = uc(OP_MUL, T4, R_M22, T1);
			7'd88: w = uc(OP_ADD, T3, T3, T4);
			7'd89: w = uc(OP_SUB, T3, A_ZERO, T3);
			7'd90: w = uc(OP_SAT, T3, T3, A_ZERO);
			7'd91: w = uc(OP_ADD, T4, R_IX, T2);
			7'd92: w = uc(OP_SAT, T4, T4, A_ZERO);
			7'd93: w = uc(OP_ADD, T5, R_IY, T3);
			7'd94: w = uc(OP_SAT, T5, T5, A_ZERO);
			7'd95: w = uc(OP_MULW, T6, T4, T4);
			7'd96: w = uc(OP_MULW, T7, T5, T5);
			7'd97: w = uc(OP_ADD, T6, T6, T7);
			7'd98: w = uc(OP_MULW, T7, A_MAXI, A_MAXI);
			7'd99: w = uc(OP_JLEU, T0, T6, T7);
			7'd100: w = uc(OP_SQRT, T6, T6, A_ZERO);
			7'd101: w = uc(OP_MULW, T7, T4, A_MAXI);
			7'd102: w = uc(OP_DIV, T4, T7, T6);
			7'd103: w = uc(OP_MULW, T7, T5, A_MAXI);
			7'd104: w = uc(OP_DIV, T5, T7, T6);
			7'd105: w = uc(OP_SUB, T6, T4, R_IX);
			7'd106: w = uc(OP_SAT, T6, T6, A_ZERO);
			7'd107: w = uc(OP_SUB, T7, T5, R_IY);
			7'd108: w = uc(OP_SAT, T7, T7, A_ZERO);
			7'd109: w = uc(OP_ADD, R_IX, T4, A_ZERO);
			7'd110: w = uc(OP_ADD, R_IY, T5, A_ZERO);
			7'd111: w = uc(OP_MUL, T8, T6, A_INVM);
			7'd112: w = uc(OP_ADD, T8, A_VX, T8);
			7'd113: w = uc(OP_SAT, D_OUTX, T8, A_ZERO);
			7'd114: w = uc(OP_MUL, T8, T7, A_INVM);
			7'd115: w = uc(OP_ADD, T8, A_VY, T8);
			7'd116: w = uc(OP_SAT, D_OUTY, T8, A_ZERO);
			7'd117: w = uc(OP_MUL, T8, R_RX, T7);
			7'd118: w = uc(OP_MUL, T9, R_RY, T6);
			7'd119: w = uc(OP_SUB, T8, T8, T9);
			7'd120: w = uc(OP_SAT, T8, T8, A_ZERO);
			7'd121: w = uc(OP_MUL, T8, A_INVI, T8);
			7'd122: w = uc(OP_ADD, T8, A_W, T8);
			7'd123: w = uc(OP_SAT, D_OUTW, T8, A_ZERO);
			default: w = uc(OP_END, T0, A_ZERO, A_ZERO);
		endcase
		return w;
	endfunction

endpackage

FILE: hdl/soft_point_drag_constraint_2d.sv
// Soft point-drag constraint for one 2D body, signed Q16.16.
// Input channel (in_valid, in_stall, fields): a word with opcode 0 builds the
// constraint for a step and applies the warm start; opcode 1 corrects the
// velocities. Each input word gives exactly one output word.
// Output channel (out_valid, out_stall, out_vel_x, out_vel_y, out_ang_vel):
// the result sits in an output register and holds while out_stall is high.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
// ready; write only while the block is idle. Indexes above 7 are ignored.
// A microcoded sequencer runs each word as a program over one shared datapath.
// Each plain step passes through a fetch state and an execute state; a divide
// or a square root adds a wait state that lasts until its unit is done. A correct
// word runs longer when its impulse is clamped: it then adds a square root and
// two divides. One word is in work at a time; the next is accepted in the cycle
// after the result moves to the output register. That move waits while the
// register holds an untaken result and out_stall is high. Reset clears the
// constraint state, restores the configuration defaults and empties the output register.
module soft_point_drag_constraint_2d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [16:0]        time_step,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] ang_vel,
	input  logic signed [17:0] rot_cos,
	input  logic signed [17:0] rot_sin,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_vel_x,
	output logic signed [31:0] out_vel_y,
	output logic signed [31:0] out_ang_vel,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	spdc_pkg::ctl_t     ctl;
	spdc_pkg::sts_t     sts;
	logic               idle, fin, accept, out_free;
	logic               out_valid_q;
	logic signed [31:0] res_x, res_y, res_w;
	logic signed [31:0] out_x_q, out_y_q, out_w_q;

	assign in_stall  = !idle;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	spdc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.opcode   (opcode),
		.out_free (out_free),
		.sts      (sts),
		.ctl      (ctl),
		.idle     (idle),
		.fin      (fin)
	);

	spdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.time_step (time_step),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.ang_vel   (ang_vel),
		.rot_cos   (rot_cos),
		.rot_sin   (rot_sin),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.target_x  (target_x),
		.target_y  (target_y),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.res_x     (res_x),
		.res_y     (res_y),
		.res_w     (res_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_x_q <= res_x;
			out_y_q <= res_y;
			out_w_q <= res_w;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_vel_x   = out_x_q;
	assign out_vel_y   = out_y_q;
	assign out_ang_vel = out_w_q;

endmodule

FILE: hdl/spdc_div.sv
module spdc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [63:0]   num,
	input  logic signed [63:0]   den,
	output logic                 done,
	output logic                 zero,
	output logic signed [63:0]   quo
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] q_q;
	logic [63:0] dm_q;
	logic        neg_q;
	logic        zero_q;
	logic [64:0] rs;
	logic [64:0] diff;
	logic        ge;

	assign rs   = {rem_q, q_q[63]};
	assign diff = rs - {1'b0, dm_q};
	assign ge   = rs >= {1'b0, dm_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			q_q    <= num[63] ? 64'(-num) : 64'(num);
			dm_q   <= den[63] ? 64'(-den) : 64'(den);
			neg_q  <= num[63] ^ den[63];
			zero_q <= (den == 64'sd0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : rs[63:0];
			q_q   <= {q_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign zero = zero_q;
	assign quo  = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

FILE: hdl/spdc_sqrt.sv
module spdc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rs;
	logic [35:0] trial;
	logic        ge;

	assign rs    = {rem_q[33:0], x_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = rs >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= ge ? (rs - trial) : rs;
			root_q <= {root_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/spdc_dp.sv
module spdc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [16:0]         time_step,
	input  logic signed [31:0]  vel_x,
	input  logic signed [31:0]  vel_y,
	input  logic signed [31:0]  ang_vel,
	input  logic signed [17:0]  rot_cos,
	input  logic signed [17:0]  rot_sin,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  target_x,
	input  logic signed [31:0]  target_y,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  spdc_pkg::ctl_t      ctl,
	output spdc_pkg::sts_t      sts,
	output logic signed [31:0]  res_x,
	output logic signed [31:0]  res_y,
	output logic signed [31:0]  res_w
);

	logic [16:0]        dt_q;
	logic signed [31:0] vx_q, vy_q, w_q, px_q, py_q, tx_q, ty_q;
	logic signed [17:0] cos_q, sin_q;
	logic [30:0]        mass_q, invm_q, invi_q, freq_q, ratio_q, maxi_q;
	logic signed [31:0] lx_q, ly_q;

	logic signed [63:0] rf_q [32];
	logic [31:0]        vld_q;
	logic signed [63:0] mem_a_q, mem_b_q, src_a_q, src_b_q;
	logic               vld_a_q, vld_b_q, sel_a_q, sel_b_q;

	logic signed [63:0] a_op, b_op, prod, mul_sh, alu, unit_res, wdata;
	logic               is_alu, we;
	logic               div_done, div_zero, sqrt_done;
	logic signed [63:0] div_quo;
	logic [31:0]        sqrt_root;
	logic signed [31:0] res_x_q, res_y_q, res_w_q;

	function automatic logic signed [63:0] src_val(input logic [5:0] addr);
		logic signed [63:0] v;
		case (addr)
			spdc_pkg::A_VX:    v = 64'(vx_q);
			spdc_pkg::A_VY:    v = 64'(vy_q);
			spdc_pkg::A_W:     v = 64'(w_q);
			spdc_pkg::A_DT:    v = {47'd0, dt_q};
			spdc_pkg::A_COS:   v = 64'(cos_q);
			spdc_pkg::A_SIN:   v = 64'(sin_q);
			spdc_pkg::A_PX:    v = 64'(px_q);
			spdc_pkg::A_PY:    v = 64'(py_q);
			spdc_pkg::A_TX:    v = 64'(tx_q);
			spdc_pkg::A_TY:    v = 64'(ty_q);
			spdc_pkg::A_MASS:  v = {33'd0, mass_q};
			spdc_pkg::A_INVM:  v = {33'd0, invm_q};
			spdc_pkg::A_INVI:  v = {33'd0, invi_q};
			spdc_pkg::A_FREQ:  v = {33'd0, freq_q};
			spdc_pkg::A_RATIO: v = {33'd0, ratio_q};
			spdc_pkg::A_MAXI:  v = {33'd0, maxi_q};
			spdc_pkg::A_LX:    v = 64'(lx_q);
			spdc_pkg::A_LY:    v = 64'(ly_q);
			spdc_pkg::A_ONE:   v = spdc_pkg::K_ONE;
			spdc_pkg::A_TWOPI: v = spdc_pkg::K_TWOPI;
			spdc_pkg::A_DAMP:  v = spdc_pkg::K_DAMP;
			default:           v = '0;
		endcase
		return v;
	endfunction

	always_ff @(posedge clk) begin
		if (load) begin
			dt_q  <= time_step;
			vx_q  <= vel_x;
			vy_q  <= vel_y;
			w_q   <= ang_vel;
			cos_q <= rot_cos;
			sin_q <= rot_sin;
			px_q  <= pos_x;
			py_q  <= pos_y;
			tx_q  <= target_x;
			ty_q  <= target_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q  <= 31'd65536;
			invm_q  <= 31'd65536;
			invi_q  <= 31'd65536;
			freq_q  <= 31'd327680;
			ratio_q <= 31'd65536;
			maxi_q  <= 31'd131072;
			lx_q    <= '0;
			ly_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spdc_pkg::CFG_MASS:  mass_q  <= cfg_data[30:0];
				spdc_pkg::CFG_INVM:  invm_q  <= cfg_data[30:0];
				spdc_pkg::CFG_INVI:  invi_q  <= cfg_data[30:0];
				spdc_pkg::CFG_FREQ:  freq_q  <= cfg_data[30:0];
				spdc_pkg::CFG_RATIO: ratio_q <= cfg_data[30:0];
				spdc_pkg::CFG_MAXI:  maxi_q  <= cfg_data[30:0];
				spdc_pkg::CFG_LX:    lx_q    <= $signed(cfg_data);
				spdc_pkg::CFG_LY:    ly_q    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Register file: an entry never written since reset reads as zero.
	always_ff @(posedge clk) begin
		if (we && !ctl.uw.dst[5]) begin
			rf_q[ctl.uw.dst[4:0]] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			mem_a_q <= rf_q[ctl.uw.sa[4:0]];
			mem_b_q <= rf_q[ctl.uw.sb[4:0]];
			src_a_q <= src_val(ctl.uw.sa);
			src_b_q <= src_val(ctl.uw.sb);
			sel_a_q <= ctl.uw.sa[5];
			sel_b_q <= ctl.uw.sb[5];
			vld_a_q <= vld_q[ctl.uw.sa[4:0]];
			vld_b_q <= vld_q[ctl.uw.sb[4:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we && !ctl.uw.dst[5]) begin
			vld_q[ctl.uw.dst[4:0]] <= 1'b1;
		end
	end

	assign a_op   = sel_a_q ? src_a_q : (vld_a_q ? mem_a_q : 64'sd0);
	assign b_op   = sel_b_q ? src_b_q : (vld_b_q ? mem_b_q : 64'sd0);
	assign prod   = $signed(a_op[31:0]) * $signed(b_op[31:0]);
	assign mul_sh = prod >>> 16;

	always_comb begin
		is_alu = 1'b1;
		case (ctl.uw.op)
			spdc_pkg::OP_MUL:  alu = mul_sh;
			spdc_pkg::OP_MULS: alu = spdc_pkg::sat32(mul_sh);
			spdc_pkg::OP_MULW: alu = prod;
			spdc_pkg::OP_ADD:  alu = a_op + b_op;
			spdc_pkg::OP_SUB:  alu = a_op - b_op;
			spdc_pkg::OP_SAT:  alu = spdc_pkg::sat32(a_op);
			default: begin
				alu    = a_op;
				is_alu = 1'b0;
			end
		endcase
	end

	spdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.ex && (ctl.uw.op == spdc_pkg::OP_DIV)),
		.num    (a_op),
		.den    (b_op),
		.done   (div_done),
		.zero   (div_zero),
		.quo    (div_quo)
	);

	spdc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.ex && (ctl.uw.op == spdc_pkg::OP_SQRT)),
		.x      (a_op),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign unit_res = (ctl.uw.op == spdc_pkg::OP_DIV)
		? (div_zero ? 64'sd0 : spdc_pkg::sat32(div_quo))
		: $signed({32'd0, sqrt_root});
	assign sts.unit_done = div_done || sqrt_done;
	assign sts.cond      = $unsigned(a_op) <= $unsigned(b_op);
	assign we    = (ctl.ex && is_alu) || sts.unit_done;
	assign wdata = sts.unit_done ? unit_res : alu;

	always_ff @(posedge clk) begin
		if (we && ctl.uw.dst == spdc_pkg::D_OUTX) res_x_q <= wdata[31:0];
		if (we && ctl.uw.dst == spdc_pkg::D_OUTY) res_y_q <= wdata[31:0];
		if (we && ctl.uw.dst == spdc_pkg::D_OUTW) res_w_q <= wdata[31:0];
	end

	assign res_x = res_x_q;
	assign res_y = res_y_q;
	assign res_w = res_w_q;

endmodule

FILE: hdl/spdc_seq.sv
module spdc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            opcode,
	input  logic            out_free,
	input  spdc_pkg::sts_t  sts,
	output spdc_pkg::ctl_t  ctl,
	output logic            idle,
	output logic            fin
);

	spdc_pkg::seq_state_t state_q, state_d;
	logic [6:0]           pc_q;
	spdc_pkg::ucode_t     uw;

	assign uw = spdc_pkg::rom_word(pc_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			spdc_pkg::S_IDLE:  if (start) state_d = spdc_pkg::S_FETCH;
			spdc_pkg::S_FETCH: state_d = spdc_pkg::S_EXEC;
			spdc_pkg::S_EXEC: begin
				case (uw.op)
					spdc_pkg::OP_DIV:  state_d = spdc_pkg::S_WAIT;
					spdc_pkg::OP_SQRT: state_d = spdc_pkg::S_WAIT;
					spdc_pkg::OP_END:  state_d = spdc_pkg::S_DONE;
					default:           state_d = spdc_pkg::S_FETCH;
				endcase
			end
			spdc_pkg::S_WAIT:  if (sts.unit_done) state_d = spdc_pkg::S_FETCH;
			spdc_pkg::S_DONE:  if (out_free) state_d = spdc_pkg::S_IDLE;
			default:           state_d = spdc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl.rd = (state_q == spdc_pkg::S_FETCH);
		ctl.ex = (state_q == spdc_pkg::S_EXEC);
		ctl.uw = uw;
		idle   = (state_q == spdc_pkg::S_IDLE);
		fin    = (state_q == spdc_pkg::S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spdc_pkg::S_IDLE;
			pc_q    <= spdc_pkg::PC_BUILD;
		end else begin
			state_q <= state_d;
			if (state_q == spdc_pkg::S_IDLE && start) begin
				pc_q <= opcode ? spdc_pkg::PC_CORRECT : spdc_pkg::PC_BUILD;
			end else if (state_q == spdc_pkg::S_EXEC) begin
				if (uw.op == spdc_pkg::OP_JLEU && sts.cond) begin
					pc_q <= uw.tgt;
				end else if (uw.op != spdc_pkg::OP_DIV && uw.op != spdc_pkg::OP_SQRT
						&& uw.op != spdc_pkg::OP_END) begin
					pc_q <= pc_q + 7'd1;
				end
			end else if (state_q == spdc_pkg::S_WAIT && sts.unit_done) begin
				pc_q <= pc_q + 7'd1;
			end
		end
	end

`ifndef SYNTHESIS
	a_wait_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spdc_pkg::S_WAIT |->
			(uw.op == spdc_pkg::OP_DIV || uw.op == spdc_pkg::OP_SQRT))
		else $error("waiting on a unit that the current step did not start");
	a_start_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spdc_pkg::S_IDLE && start) |=>
			(state_q == spdc_pkg::S_FETCH &&
			(pc_q == spdc_pkg::PC_BUILD || pc_q == spdc_pkg::PC_CORRECT)))
		else $error("program did not enter at an entry point");
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> state_q == spdc_pkg::S_IDLE)
		else $error("result handed off but sequencer not idle");
	a_done_unit: assert property (@(posedge clk) disable iff (!arst_n)
		sts.unit_done |-> state_q == spdc_pkg::S_WAIT)
		else $error("unit finished outside a wait step");
`endif

endmodule

FILE: bench/testbench.sv
module testbench;

	localparam bit OPC_BUILD = 1'b0;
	localparam bit OPC_CORRECT = 1'b1;
	localparam int STALL_LIMIT = 4000;
	localparam longint Q_ONE = 65536;
	localparam longint Q_TWO_PI = 411775;
	localparam longint Q_ANG_DAMP = 64881;
	localparam logic [3:0] CFG_UNUSED_LO = 4'd8;
	localparam logic [3:0] CFG_UNUSED_HI = 4'd15;

	typedef struct {
		bit                op;
		bit [16:0]         dt;
		int                vx, vy, w;
		logic signed [17:0] c, s;
		int                px, py, tx, ty;
	} drag_word_t;

	typedef struct {
		int vx, vy, w;
	} vel_set_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic opcode;
	logic [16:0] time_step;
	logic signed [31:0] vel_x, vel_y, ang_vel, pos_x, pos_y, target_x, target_y;
	logic signed [17:0] rot_cos, rot_sin;
	logic out_valid, out_stall;
	logic signed [31:0] out_vel_x, out_vel_y, out_ang_vel;
	logic cfg_valid, cfg_ready;
	logic [3:0] cfg_index;
	logic [31:0] cfg_data;

	longint regs_m[8];
	longint arm_m[2], inv_mass_m[3], bias_m[2], impulse_m[2];
	vel_set_t pending_vel[$];
	int errors = 0;
	int idle_cnt = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	soft_point_drag_constraint_2d u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .time_step(time_step), .vel_x(vel_x), .vel_y(vel_y),
		.ang_vel(ang_vel), .rot_cos(rot_cos), .rot_sin(rot_sin), .pos_x(pos_x),
		.pos_y(pos_y), .target_x(target_x), .target_y(target_y),
		.out_valid(out_valid), .out_stall(out_stall), .out_vel_x(out_vel_x),
		.out_vel_y(out_vel_y), .out_ang_vel(out_ang_vel), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fxmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint fxmuls(longint a, longint b);
		return clamp32(fxmul(a, b));
	endfunction

	function automatic longint fxdiv(longint a, longint b);
		if (b == 0) return 0;
		return clamp32((a * Q_ONE) / b);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
		return clamp32(fxmul(ax, by) - fxmul(ay, bx));
	endfunction

	function automatic void reset_drag_state();
		regs_m[0] = Q_ONE;
		regs_m[1] = Q_ONE;
		regs_m[2] = Q_ONE;
		regs_m[3] = 5 * Q_ONE;
		regs_m[4] = Q_ONE;
		regs_m[5] = 2 * Q_ONE;
		regs_m[6] = 0;
		regs_m[7] = 0;
		arm_m = '{0, 0};
		inv_mass_m = '{0, 0, 0};
		bias_m = '{0, 0};
		impulse_m = '{0, 0};
	endfunction

	function automatic vel_set_t drag_velocities(drag_word_t d);
		longint mass, invm, invi, vx, vy, w, dt, rx, ry, om, k, cd, den, cfm, erp;
		longint a11, a12, a22, det, cdx, cdy, cx, cy, ox, oy, nx, ny, dx, dy, len, mx;
		longint unsigned lsq, msq;
		vel_set_t r;
		mass = regs_m[0];
		invm = regs_m[1];
		invi = regs_m[2];
		vx = d.vx;
		vy = d.vy;
		w = d.w;
		if (d.op == OPC_BUILD) begin
			dt = longint'(d.dt);
			rx = clamp32(fxmul(d.c, regs_m[6]) - fxmul(d.s, regs_m[7]));
			ry = clamp32(fxmul(d.s, regs_m[6]) + fxmul(d.c, regs_m[7]));
			arm_m[0] = rx;
			arm_m[1] = ry;
			om = fxmuls(Q_TWO_PI, regs_m[3]);
			k = fxmuls(fxmuls(mass, om), om);
			cd = fxmuls(fxmuls(clamp32(2 * regs_m[4]), mass), om);
			den = fxmuls(clamp32(cd + fxmuls(k, dt)), dt);
			cfm = (den != 0) ? fxdiv(Q_ONE, den) : 0;
			erp = fxmuls(fxmuls(dt, k), cfm);
			a11 = clamp32(invm + fxmul(fxmuls(invi, ry), ry) + cfm);
			a22 = clamp32(invm + fxmul(fxmuls(invi, rx), rx) + cfm);
			a12 = clamp32(-fxmul(fxmuls(invi, rx), ry));
			det = clamp32(fxmul(a11, a22) - fxmul(a12, a12));
			if (det != 0) begin
				inv_mass_m[0] = fxdiv(a22, det);
				inv_mass_m[1] = fxdiv(clamp32(-a12), det);
				inv_mass_m[2] = fxdiv(a11, det);
			end else begin
				inv_mass_m = '{0, 0, 0};
			end
			bias_m[0] = fxmuls(erp, clamp32(clamp32(longint'(d.px) + rx) - d.tx));
			bias_m[1] = fxmuls(erp, clamp32(clamp32(longint'(d.py) + ry) - d.ty));
			vx = clamp32(vx + fxmul(impulse_m[0], invm));
			vy = clamp32(vy + fxmul(impulse_m[1], invm));
			w = clamp32(w + fxmul(invi, cross2(rx, ry, impulse_m[0], impulse_m[1])));
			w = fxmuls(w, Q_ANG_DAMP);
		end else begin
			rx = arm_m[0];
			ry = arm_m[1];
			mx = regs_m[5];
			cdx = clamp32(vx - fxmul(w, ry) + bias_m[0]);
			cdy = clamp32(vy + fxmul(w, rx) + bias_m[1]);
			cx = clamp32(-(fxmul(inv_mass_m[0], cdx) + fxmul(inv_mass_m[1], cdy)));
			cy = clamp32(-(fxmul(inv_mass_m[1], cdx) + fxmul(inv_mass_m[2], cdy)));
			ox = impulse_m[0];
			oy = impulse_m[1];
			nx = clamp32(ox + cx);
			ny = clamp32(oy + cy);
			lsq = longint'(nx * nx) + longint'(ny * ny);
			msq = mx * mx;
			if (lsq > msq) begin
				len = longint'(floor_sqrt(lsq));
				if (len > 0) begin
					nx = clamp32((nx * mx) / len);
					ny = clamp32((ny * mx) / len);
				end
			end
			impulse_m[0] = nx;
			impulse_m[1] = ny;
			dx = clamp32(nx - ox);
			dy = clamp32(ny - oy);
			vx = clamp32(vx + fxmul(dx, invm));
			vy = clamp32(vy + fxmul(dy, invm));
			w = clamp32(w + fxmul(invi, cross2(rx, ry, dx, dy)));
		end
		r.vx = int'(vx);
		r.vy = int'(vy);
		r.w = int'(w);
		return r;
	endfunction

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

	always @(posedge clk) begin
		vel_set_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vel.size() == 0) begin
				$display("%0t: unexpected word %0d %0d %0d", $time, out_vel_x,
					out_vel_y, out_ang_vel);
				errors++;
			end else begin
				e = pending_vel.pop_front();
				if (out_vel_x !== e.vx) begin
					$display("%0t: out_vel_x expected %0d actual %0d", $time, e.vx, out_vel_x);
					errors++;
				end
				if (out_vel_y !== e.vy) begin
					$display("%0t: out_vel_y expected %0d actual %0d", $time, e.vy, out_vel_y);
					errors++;
				end
				if (out_ang_vel !== e.w) begin
					$display("%0t: out_ang_vel expected %0d actual %0d", $time, e.w,
						out_ang_vel);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_word(drag_word_t d);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= d.op;
		time_step <= d.dt;
		vel_x <= d.vx;
		vel_y <= d.vy;
		ang_vel <= d.w;
		rot_cos <= d.c;
		rot_sin <= d.s;
		pos_x <= d.px;
		pos_y <= d.py;
		target_x <= d.tx;
		target_y <= d.ty;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_vel.push_back(drag_velocities(d));
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_vel.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= spdc_pkg::CFG_MAXI)
			regs_m[idx] = longint'(val & 32'h7FFF_FFFF);
		else if (idx <= spdc_pkg::CFG_LY)
			regs_m[idx] = longint'(signed'(val));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(longint m, longint im, longint ii, longint f, longint r,
			longint mi, longint lx, longint ly);
		write_reg(spdc_pkg::CFG_MASS, 32'(m));
		write_reg(spdc_pkg::CFG_INVM, 32'(im));
		write_reg(spdc_pkg::CFG_INVI, 32'(ii));
		write_reg(spdc_pkg::CFG_FREQ, 32'(f));
		write_reg(spdc_pkg::CFG_RATIO, 32'(r));
		write_reg(spdc_pkg::CFG_MAXI, 32'(mi));
		write_reg(spdc_pkg::CFG_LX, 32'(lx));
		write_reg(spdc_pkg::CFG_LY, 32'(ly));
	endtask

	function automatic drag_word_t plain_word(bit op, bit wild);
		drag_word_t d;
		d.op = op;
		if (wild) begin
			d.dt = 17'($urandom_range(0, 65536));
			d.vx = $urandom;
			d.vy = $urandom;
			d.w = $urandom;
			d.c = 18'($urandom_range(0, 131072) - 65536);
			d.s = 18'($urandom_range(0, 131072) - 65536);
			d.px = $urandom;
			d.py = $urandom;
			d.tx = $urandom;
			d.ty = $urandom;
		end else begin
			d.dt = 17'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65536) : 1092);
			d.vx = $urandom_range(0, 1 << 22) - (1 << 21);
			d.vy = $urandom_range(0, 1 << 22) - (1 << 21);
			d.w = $urandom_range(0, 1 << 20) - (1 << 19);
			d.c = 18'($urandom_range(0, 131072) - 65536);
			d.s = 18'($urandom_range(0, 131072) - 65536);
			d.px = $urandom_range(0, 1 << 24) - (1 << 23);
			d.py = $urandom_range(0, 1 << 24) - (1 << 23);
			d.tx = $urandom_range(0, 1 << 24) - (1 << 23);
			d.ty = $urandom_range(0, 1 << 24) - (1 << 23);
		end
		return d;
	endfunction

	task automatic test_before_build();
		drag_word_t d;
		d = plain_word(OPC_CORRECT, 1'b1);
		d.vx = 32'h7FFF_FFFF;
		d.vy = 32'h8000_0000;
		d.w = 32'h7FFF_FFFF;
		send_word(d);
		send_word(plain_word(OPC_CORRECT, 1'b1));
	endtask

	task automatic test_extremes();
		drag_word_t d;
		write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		d = plain_word(OPC_BUILD, 1'b1);
		d.dt = 17'd65536;
		d.c = 18'sd65536;
		d.s = -18'sd65536;
		d.vx = 32'h8000_0000;
		d.px = 32'h7FFF_FFFF;
		d.tx = 32'h8000_0000;
		send_word(d);
		send_word(plain_word(OPC_CORRECT, 1'b1));
		d.dt = 17'd0;
		d.c = -18'sd65536;
		d.s = 18'sd65536;
		send_word(d);
		send_word(plain_word(OPC_CORRECT, 1'b1));
		write_all(0, 0, 0, 0, 0, 0, 0, 0);
		send_word(plain_word(OPC_BUILD, 1'b1));
		send_word(plain_word(OPC_CORRECT, 1'b1));
		write_reg(CFG_UNUSED_LO, 32'hFFFF_FFFF);
		write_reg(CFG_UNUSED_HI, 32'h1234_5678);
		send_word(plain_word(OPC_CORRECT, 1'b1));
	endtask

	task automatic test_singular_and_clamp();
		write_all(Q_ONE, 0, 0, 5 * Q_ONE, Q_ONE, 2 * Q_ONE, Q_ONE, -Q_ONE);
		send_word(plain_word(OPC_BUILD, 1'b0));
		send_word(plain_word(OPC_CORRECT, 1'b0));
		write_all(2 * Q_ONE, Q_ONE / 2, Q_ONE, 10 * Q_ONE, Q_ONE / 2, 1, Q_ONE, Q_ONE);
		send_word(plain_word(OPC_BUILD, 1'b0));
		repeat (3) send_word(plain_word(OPC_CORRECT, 1'b1));
		send_word(plain_word(OPC_BUILD, 1'b0));
		send_word(plain_word(OPC_CORRECT, 1'b0));
	endtask

	task automatic random_config();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 6)
			write_all($urandom_range(1 << 14, 8 << 16), $urandom_range(1 << 13, 4 << 16),
				$urandom_range(0, 4 << 16), $urandom_range(0, 30 << 16),
				$urandom_range(0, 2 << 16), $urandom_range(1 << 10, 100 << 16),
				$urandom_range(0, 8 << 16) - (4 << 16),
				$urandom_range(0, 8 << 16) - (4 << 16));
		else if (kind < 9)
			write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		else
			write_all(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0,
				32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_random(int items);
		int sent, n;
		bit wild;
		sent = 0;
		while (sent < items) begin
			if (sent % 40 == 0) random_config();
			wild = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_word(plain_word(1'($urandom_range(0, 1)), 1'b1));
				sent++;
			end else begin
				send_word(plain_word(OPC_BUILD, wild));
				n = $urandom_range(1, 6);
				repeat (n) send_word(plain_word(OPC_CORRECT, wild));
				sent += n + 1;
			end
			if ($urandom_range(0, 15) == 0) drain();
		end
		drain();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = 1'b0;
		time_step = '0;
		vel_x = '0;
		vel_y = '0;
		ang_vel = '0;
		rot_cos = '0;
		rot_sin = '0;
		pos_x = '0;
		pos_y = '0;
		target_x = '0;
		target_y = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		reset_drag_state();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		tx_idle_pct = 22;
		rx_idle_pct = 56;
		test_before_build();
		test_extremes();
		test_singular_and_clamp();
		test_random(160);
		tx_idle_pct = 56;
		rx_idle_pct = 22;
		test_random(160);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random(160);
		drain();
		repeat (500) @(negedge clk);
		if (errors == 0 && pending_vel.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
